// ----- rtl/sbm_pkg.sv -----
`default_nettype none
package sbm_pkg;

    localparam int unsigned PRG_SLOTS = 4;
    localparam int unsigned CHR_SLOTS = 8;
    localparam int unsigned JOBQ_DEPTH_DEF = 4;

    localparam int unsigned JOB_CNT_W = $clog2(CHR_SLOTS + 1);

    // result targets
    localparam logic [1:0] TGT_PRG    = 2'd0;
    localparam logic [1:0] TGT_CHR    = 2'd1;
    localparam logic [1:0] TGT_MIRROR = 2'd2;

    // mapper register selects (address bits 14:13)
    localparam logic [1:0] REG_CONTROL = 2'd0;
    localparam logic [1:0] REG_CHR0    = 2'd1;
    localparam logic [1:0] REG_CHR1    = 2'd2;
    localparam logic [1:0] REG_PRG     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_IS_RAM     = 2'd1;

    localparam logic [1:0] TICKS_ONE = 2'd1;
    localparam logic [1:0] TICKS_SAT = 2'd2;

    localparam logic [2:0] SHIFT_FIFTH = 3'd4;

    localparam logic [4:0] CTRL_RESET_BITS = 5'h0C;

    // one run of remaps: slot and bank both step by one per result
    typedef struct packed {
        logic [1:0]           target;
        logic [2:0]           slot;
        logic [7:0]           bank;
        logic [JOB_CNT_W-1:0] count;
    } t_job;

endpackage
`default_nettype wire

// ----- rtl/sbm_front.sv -----
`default_nettype none
module sbm_front
    import sbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic       i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       i_jq_full,
    output logic            o_jq_push,
    output t_job            o_jq_job
);

    logic [6:0] r_prg_bank_count, n_prg_bank_count;
    logic       r_chr_is_ram, n_chr_is_ram;
    logic [4:0] r_shift, n_shift;
    logic [2:0] r_shift_cnt, n_shift_cnt;
    logic [4:0] r_regs [4];
    logic [4:0] n_regs [4];
    logic [1:0] r_ticks, n_ticks;

    logic       accept;
    logic [4:0] shifted;
    logic [4:0] ctrl;
    logic [1:0] sel;
    logic       job_valid;
    t_job       job;

    assign accept      = i_push && !i_jq_full;
    assign o_full      = i_jq_full;
    assign o_cfg_ready = 1'b1;
    assign shifted     = {i_write_data[0], r_shift[4:1]};
    assign sel         = i_address[14:13];
    assign ctrl        = (sel == REG_CONTROL) ? shifted : r_regs[REG_CONTROL];

    always_comb begin
        n_prg_bank_count = r_prg_bank_count;
        n_chr_is_ram     = r_chr_is_ram;
        n_shift          = r_shift;
        n_shift_cnt      = r_shift_cnt;
        n_regs           = r_regs;
        n_ticks          = r_ticks;
        job_valid        = 1'b0;
        job              = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRG_BANK_COUNT: n_prg_bank_count = i_cfg_data;
                CFG_CHR_IS_RAM:     n_chr_is_ram     = i_cfg_data[0];
                default: ;
            endcase
        end

        if (accept) begin
            if (i_action) begin
                if (r_ticks != TICKS_SAT) begin
                    n_ticks = r_ticks + 2'd1;
                end
            end else if (r_ticks != TICKS_ONE) begin
                n_ticks = '0;
                if (i_write_data[7]) begin
                    n_shift                 = '0;
                    n_shift_cnt             = '0;
                    n_regs[REG_CONTROL]     = r_regs[REG_CONTROL] | CTRL_RESET_BITS;
                    job_valid               = 1'b1;
                    job.target              = TGT_PRG;
                    job.slot                = 3'd2;
                    job.bank                = {1'b0, r_prg_bank_count} - 8'd2;
                    job.count               = JOB_CNT_W'(2);
                end else if (r_shift_cnt != SHIFT_FIFTH) begin
                    n_shift     = shifted;
                    n_shift_cnt = r_shift_cnt + 3'd1;
                end else begin
                    n_shift     = shifted;
                    n_shift_cnt = '0;
                    n_regs[sel] = shifted;
                    case (sel)
                        REG_CONTROL: begin
                            job_valid  = 1'b1;
                            job.target = TGT_MIRROR;
                            job.slot   = '0;
                            job.bank   = {6'd0, ctrl[1:0]};
                            job.count  = JOB_CNT_W'(1);
                        end
                        REG_CHR0, REG_CHR1: begin
                            job.target = TGT_CHR;
                            if (!ctrl[4]) begin
                                // 8KB mode: only bank 0 with ROM, low bit dropped
                                job_valid = (sel == REG_CHR0) && !r_chr_is_ram;
                                job.slot  = '0;
                                job.bank  = {1'b0, shifted[4:1], 3'b000};
                                job.count = JOB_CNT_W'(CHR_SLOTS);
                            end else begin
                                job_valid = 1'b1;
                                job.slot  = (sel == REG_CHR0) ? 3'd0 : 3'd4;
                                job.bank  = r_chr_is_ram ? {5'd0, job.slot}
                                                         : {1'b0, shifted, 2'b00};
                                job.count = JOB_CNT_W'(CHR_SLOTS / 2);
                            end
                        end
                        REG_PRG: begin
                            job_valid  = 1'b1;
                            job.target = TGT_PRG;
                            if (ctrl[3]) begin
                                job.slot  = ctrl[2] ? 3'd0 : 3'd2;
                                job.bank  = {3'd0, shifted[3:0], 1'b0};
                                job.count = JOB_CNT_W'(2);
                            end else begin
                                job.slot  = '0;
                                job.bank  = {3'd0, shifted[3:1], 2'b00};
                                job.count = JOB_CNT_W'(PRG_SLOTS);
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign o_jq_push = job_valid;
    assign o_jq_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= 7'd16;
            r_chr_is_ram     <= 1'b0;
            r_shift          <= '0;
            r_shift_cnt      <= '0;
            r_regs[0]        <= CTRL_RESET_BITS;
            r_regs[1]        <= '0;
            r_regs[2]        <= '0;
            r_regs[3]        <= '0;
            r_ticks          <= '0;
        end else begin
            r_prg_bank_count <= n_prg_bank_count;
            r_chr_is_ram     <= n_chr_is_ram;
            r_shift          <= n_shift;
            r_shift_cnt      <= n_shift_cnt;
            r_regs           <= n_regs;
            r_ticks          <= n_ticks;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sbm_jobq.sv -----
`default_nettype none
module sbm_jobq
    import sbm_pkg::*;
#(
    parameter int unsigned DEPTH = JOBQ_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sbm_back.sv -----
`default_nettype none
module sbm_back
    import sbm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_jq_empty,
    input  wire t_job i_jq_job,
    output logic      o_jq_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output logic [1:0] o_target,
    output logic [2:0] o_slot,
    output logic [7:0] o_bank,
    output logic      o_last
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [1:0] r_target;
    logic [2:0] r_slot;
    logic [7:0] r_bank;
    logic       r_last;

    logic       load;
    logic       is_last;

    // output register frees up when empty or being taken this beat
    assign load    = !i_jq_empty && (!r_valid || i_pop);
    assign is_last = ({1'b0, r_idx} == (i_jq_job.count - JOB_CNT_W'(1)));
    assign o_jq_pop = load && is_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (i_pop && r_valid) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? '0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_target <= i_jq_job.target;
            r_slot   <= i_jq_job.slot + r_idx;
            r_bank   <= i_jq_job.bank + {5'd0, r_idx};
            r_last   <= is_last;
        end
    end

    assign o_empty  = !r_valid;
    assign o_target = r_target;
    assign o_slot   = r_slot;
    assign o_bank   = r_bank;
    assign o_last   = r_last;

endmodule
`default_nettype wire

// ----- rtl/serial_bank_mapper_unit.sv -----
// serial bank mapper: cartridge bank controller loaded through a 5-bit serial register
// input queue side: drive i_action/i_address/i_write_data and raise push; the beat
//   is taken when full is low. a tick (i_action high) or a write that causes no
//   remap leaves nothing on the result side
// result queue side: while empty is low the oldest result sits on o_target, o_slot,
//   o_bank and o_last; raise pop to take it. o_last marks the final result of a write
// configuration: i_cfg_valid with i_cfg_index (0 prg bank count, 1 chr is ram) and
//   i_cfg_data; o_cfg_ready is always high, other indexes are ignored
// path: the first result of a write passes through the job queue and then the result register
// throughput: one result per cycle from the emit stage while pop is high; a write yields
//   up to eight results, and a full chr remap holds the emit stage until its last is out.
//   the front takes one beat per cycle until the job queue (JOBQ_DEPTH runs of remaps) fills
// stall: with pop low the result register holds, the emit stage waits, the job
//   queue fills and then full rises
// reset: synchronous, active low; queues empty, control register 0x0C, others zero,
//   prg bank count 16, chr is ram 0
`default_nettype none
module serial_bank_mapper_unit
    import sbm_pkg::*;
#(
    parameter int unsigned JOBQ_DEPTH = JOBQ_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_target,
    output logic [2:0]       o_slot,
    output logic [7:0]       o_bank,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);

    logic jq_push;
    logic jq_full;
    logic jq_pop;
    logic jq_empty;
    t_job jq_in;
    t_job jq_out;

    sbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_jq_full    (jq_full),
        .o_jq_push    (jq_push),
        .o_jq_job     (jq_in)
    );

    sbm_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_job   (jq_in),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_job   (jq_out),
        .o_empty (jq_empty)
    );

    sbm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_jq_empty (jq_empty),
        .i_jq_job   (jq_out),
        .o_jq_pop   (jq_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_target   (o_target),
        .o_slot     (o_slot),
        .o_bank     (o_bank),
        .o_last     (o_last)
    );

    a_jq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jq_full |-> !jq_push)
        else $error("job queue written while full");

    a_jq_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jq_empty |-> !jq_pop)
        else $error("job queue popped while empty");

    a_jobs_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jq_push |-> (jq_in.count != '0))
        else $error("empty run of remaps queued");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result side not empty after reset");

endmodule
`default_nettype wire

// ----- bench/serial_bank_mapper_unit_tb.sv -----
`default_nettype none
module serial_bank_mapper_unit_tb;
    import sbm_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int LOAD_WRITES  = 5;
    localparam int PHASES       = 7;
    localparam int PHASE_WRITES = 12;
    localparam int FILL_WRITES  = 8;

    // indexes the block decodes to nothing
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0] target;
        logic [2:0] slot;
        logic [7:0] bank;
        logic       last;
    } t_remap;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  n_fix;
        t_remap      fix0;
        t_remap      fix1;
    } t_item;

    localparam t_remap NO_REMAP = '0;
    // default bank count of 16 puts the fixed slots on banks 14 and 15
    localparam t_remap FIXED_LO = '{TGT_PRG, 3'd2, 8'd14, 1'b0};
    localparam t_remap FIXED_HI = '{TGT_PRG, 3'd3, 8'd15, 1'b1};
    localparam t_remap MIRROR_H = '{TGT_MIRROR, 3'd0, 8'd3, 1'b1};

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_action;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        empty;
    logic        pop;
    logic [1:0]  o_target;
    logic [2:0]  o_slot;
    logic [7:0]  o_bank;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;

    // mirror of the mapper state
    logic [4:0] sr_value;
    logic [2:0] sr_count;
    logic [4:0] mreg [4];
    logic [1:0] tick_age;
    logic [6:0] prg_banks;
    logic       chr_ram;

    t_remap step_remaps[$];
    t_remap pending_remaps[$];
    t_item  dir_tab[$];

    bit tx_burst;
    bit hold_request;
    int n_errors;
    int n_writes;
    int n_ticks;
    int n_beats;
    int n_cfg;

    logic [6:0] phase_banks [PHASES] = '{7'd16, 7'd2, 7'd64, 7'd0, 7'd127, 7'd1, 7'd16};
    logic       phase_ram   [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    serial_bank_mapper_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .empty        (empty),
        .pop          (pop),
        .o_target     (o_target),
        .o_slot       (o_slot),
        .o_bank       (o_bank),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_item mk_item(input logic act, input logic [15:0] adr,
                                      input logic [7:0] dat, input logic [1:0] nf,
                                      input t_remap f0, input t_remap f1);
        t_item it;
        it.action     = act;
        it.address    = adr;
        it.write_data = dat;
        it.n_fix      = nf;
        it.fix0       = f0;
        it.fix1       = f1;
        return it;
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_remap(input logic [1:0] tgt, input logic [2:0] slt,
                                      input logic [7:0] bnk);
        t_remap rm;
        rm.target = tgt;
        rm.slot   = slt;
        rm.bank   = bnk;
        rm.last   = 1'b0;
        step_remaps.push_back(rm);
    endfunction

    function automatic void predict_remaps(input logic act, input logic [15:0] adr,
                                           input logic [7:0] dat);
        logic [1:0] sel;
        logic [4:0] ctrl;
        logic [7:0] b;
        logic [2:0] first;
        int i;
        step_remaps.delete();
        if (act) begin
            if (tick_age != TICKS_SAT)
                tick_age = tick_age + 2'd1;
            return;
        end
        // a write landing one tick after the previous one is lost
        if (tick_age == TICKS_ONE)
            return;
        tick_age = '0;
        if (dat[7]) begin
            sr_value = '0;
            sr_count = '0;
            mreg[REG_CONTROL] = mreg[REG_CONTROL] | CTRL_RESET_BITS;
            add_remap(TGT_PRG, 3'd2, {1'b0, prg_banks} - 8'd2);
            add_remap(TGT_PRG, 3'd3, {1'b0, prg_banks} - 8'd1);
        end else begin
            sr_value = {dat[0], sr_value[4:1]};
            if (sr_count != SHIFT_FIFTH) begin
                sr_count = sr_count + 3'd1;
                return;
            end
            sr_count = '0;
            sel = adr[14:13];
            mreg[sel] = sr_value;
            ctrl = mreg[REG_CONTROL];
            case (sel)
                REG_CONTROL: add_remap(TGT_MIRROR, 3'd0, {6'd0, ctrl[1:0]});
                REG_PRG: begin
                    if (ctrl[3]) begin
                        // 16KB mode: bit 2 says which half is switchable
                        first = ctrl[2] ? 3'd0 : 3'd2;
                        b = {3'd0, mreg[REG_PRG][3:0], 1'b0};
                        add_remap(TGT_PRG, first, b);
                        add_remap(TGT_PRG, first + 3'd1, b + 8'd1);
                    end else begin
                        b = {3'd0, mreg[REG_PRG][3:1], 2'b00};
                        for (i = 0; i < PRG_SLOTS; i++)
                            add_remap(TGT_PRG, i[2:0], b + i[7:0]);
                    end
                end
                default: begin
                    if (!ctrl[4]) begin
                        // 8KB chr: only chr bank 0 counts, low bit dropped
                        if (sel == REG_CHR0 && !chr_ram) begin
                            b = {1'b0, mreg[REG_CHR0][4:1], 3'b000};
                            for (i = 0; i < CHR_SLOTS; i++)
                                add_remap(TGT_CHR, i[2:0], b + i[7:0]);
                        end
                    end else begin
                        first = (sel == REG_CHR0) ? 3'd0 : 3'd4;
                        b = chr_ram ? {5'd0, first} : {1'b0, mreg[sel], 2'b00};
                        for (i = 0; i < CHR_SLOTS / 2; i++)
                            add_remap(TGT_CHR, first + i[2:0], b + i[7:0]);
                    end
                end
            endcase
        end
        if (step_remaps.size() != 0)
            step_remaps[step_remaps.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        @(negedge i_clk);
        push         <= 1'b1;
        i_action     <= it.action;
        i_address    <= it.address;
        i_write_data <= it.write_data;
        do
            @(posedge i_clk);
        while (full);
        predict_remaps(it.action, it.address, it.write_data);
        if (it.n_fix != 2'd0) begin
            pending_remaps.push_back(it.fix0);
            if (it.n_fix == 2'd2)
                pending_remaps.push_back(it.fix1);
        end else begin
            foreach (step_remaps[k])
                pending_remaps.push_back(step_remaps[k]);
        end
        if (it.action)
            n_ticks++;
        else
            n_writes++;
        gap = tx_burst ? 0 : next_gap();
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    task automatic send_tick();
        send_item(mk_item(1'b1, 16'($urandom), 8'($urandom), 2'd0, NO_REMAP, NO_REMAP));
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_remaps.size() != 0)
            @(posedge i_clk);
        // let the last beat clear before the config moves
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [6:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_PRG_BANK_COUNT)
            prg_banks = val;
        else if (idx == CFG_CHR_IS_RAM)
            chr_ram = val[0];
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n_target, input bit burst);
        int done;
        int r;
        logic act;
        tx_burst = burst;
        done = 0;
        while (done < n_target) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_item(mk_item(1'b0, 16'($urandom), 8'h80 | 8'($urandom), 2'd0,
                                  NO_REMAP, NO_REMAP));
                done++;
            end else if (r < 75) begin
                // full register load, ticks only in pairs or more so nothing is lost
                repeat (LOAD_WRITES) begin
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(2, 3)) send_tick();
                    send_item(mk_item(1'b0, 16'($urandom), {1'b0, 7'($urandom)}, 2'd0,
                                      NO_REMAP, NO_REMAP));
                    done++;
                end
            end else if (r < 90) begin
                act = 1'($urandom);
                send_item(mk_item(act, 16'($urandom), 8'($urandom), 2'd0,
                                  NO_REMAP, NO_REMAP));
                if (!act)
                    done++;
            end else begin
                // write straight after a tick, dropped when that tick is the only one since the last write
                send_tick();
                send_item(mk_item(1'b0, 16'($urandom), 8'($urandom), 2'd0,
                                  NO_REMAP, NO_REMAP));
            end
        end
        tx_burst = 1'b0;
    endtask

    // result side
    initial begin : result_sink
        int stall;
        int calm;
        int hold_left;
        t_remap want;
        pop = 1'b0;
        stall = 0;
        calm = 0;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                n_beats++;
                if (pending_remaps.size() == 0) begin
                    $display("%0t: unexpected beat: target %0d slot %0d bank %0d last %0d",
                             $time, o_target, o_slot, o_bank, o_last);
                    n_errors++;
                end else begin
                    want = pending_remaps.pop_front();
                    if (o_target !== want.target || o_slot !== want.slot ||
                        o_bank !== want.bank || o_last !== want.last) begin
                        $display("%0t: expected target %0d slot %0d bank %0d last %0d",
                                 $time, want.target, want.slot, want.bank, want.last);
                        $display("%0t:      got target %0d slot %0d bank %0d last %0d",
                                 $time, o_target, o_slot, o_bank, o_last);
                        n_errors++;
                    end
                end
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 19) == 0)
                    calm = $urandom_range(10, 40);
                else
                    stall = next_gap();
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 500000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int p;
        logic [6:0] banks;
        push = 1'b0;
        i_action = 1'b0;
        i_address = '0;
        i_write_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        tx_burst = 1'b0;
        hold_request = 1'b0;
        n_errors = 0;
        n_writes = 0;
        n_ticks = 0;
        n_beats = 0;
        n_cfg = 0;
        sr_value = '0;
        sr_count = '0;
        mreg[REG_CONTROL] = CTRL_RESET_BITS;
        mreg[REG_CHR0] = '0;
        mreg[REG_CHR1] = '0;
        mreg[REG_PRG] = '0;
        tick_age = '0;
        prg_banks = 7'd16;
        chr_ram = 1'b0;

        // reset write, then control loaded with 0x13 (4KB chr, 32KB prg, horizontal)
        dir_tab.push_back(mk_item(1'b0, 16'hFFFF, 8'h80, 2'd2, FIXED_LO, FIXED_HI));
        dir_tab.push_back(mk_item(1'b0, 16'h8000, 8'h7F, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b0, 16'h8000, 8'h01, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b0, 16'h8000, 8'h7E, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b0, 16'h8000, 8'h00, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b0, 16'h9FFF, 8'h41, 2'd1, MIRROR_H, NO_REMAP));
        // single tick swallows the next write, two ticks do not
        dir_tab.push_back(mk_item(1'b1, 16'h0000, 8'hFF, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b0, 16'hA000, 8'h01, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b1, 16'hFFFF, 8'h00, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b1, 16'hFFFF, 8'h00, 2'd0, NO_REMAP, NO_REMAP));
        // chr bank 0 through an address below 0x8000, then prg bank 0
        repeat (LOAD_WRITES)
            dir_tab.push_back(mk_item(1'b0, 16'h3FFF, 8'h01, 2'd0, NO_REMAP, NO_REMAP));
        repeat (LOAD_WRITES)
            dir_tab.push_back(mk_item(1'b0, 16'hE000, 8'h00, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b0, 16'hC000, 8'h80, 2'd2, FIXED_LO, FIXED_HI));
        // reset write cuts a half-filled shift
        repeat (3)
            dir_tab.push_back(mk_item(1'b0, 16'hC000, 8'h01, 2'd0, NO_REMAP, NO_REMAP));
        dir_tab.push_back(mk_item(1'b0, 16'h8000, 8'hFF, 2'd2, FIXED_LO, FIXED_HI));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k])
            send_item(dir_tab[k]);

        for (p = 0; p < PHASES; p++) begin
            drain();
            banks = (p == PHASES - 1) ? 7'($urandom_range(2, 64)) : phase_banks[p];
            write_cfg(CFG_PRG_BANK_COUNT, banks);
            write_cfg(CFG_CHR_IS_RAM, {6'($urandom), phase_ram[p]});
            if (p == 2)
                write_cfg(CFG_SPARE_A, 7'($urandom));
            if (p == 4)
                write_cfg(CFG_SPARE_B, 7'h7F);
            // long receiver hold with the sender pushing reset writes flat out
            if (p == 2) begin
                hold_request = 1'b1;
                tx_burst = 1'b1;
                repeat (FILL_WRITES)
                    send_item(mk_item(1'b0, 16'($urandom), 8'h80 | 8'($urandom), 2'd0,
                                      NO_REMAP, NO_REMAP));
                tx_burst = 1'b0;
            end
            random_phase(PHASE_WRITES, p == 2 || p == 4);
        end
        drain();

        $display("covered %0d writes and %0d ticks, %0d remap beats checked",
                 n_writes, n_ticks, n_beats);
        $display("%0d config writes over %0d bank settings, incl. wrap and spare indexes",
                 n_cfg, PHASES);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
